// ----- design/i2cm_pkg.sv -----
// Shared types and codes for the I2C master byte engine.
// Holds command codes, sequence step codes and the config/result structs.
// No dependencies.
package i2cm_pkg;

   // command codes carried in req_tuser
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_WACK  = 3'd4;
   localparam logic [2:0] CMD_READ  = 3'd5;

   // sequence steps
   localparam logic [3:0] STP_IDLE     = 4'd0;
   localparam logic [3:0] STP_ST_A     = 4'd1;
   localparam logic [3:0] STP_ST_B     = 4'd2;
   localparam logic [3:0] STP_SP_A     = 4'd3;
   localparam logic [3:0] STP_SP_B     = 4'd4;
   localparam logic [3:0] STP_WR_PRE   = 4'd5;
   localparam logic [3:0] STP_WR_HI    = 4'd6;
   localparam logic [3:0] STP_WR_LO    = 4'd7;
   localparam logic [3:0] STP_WA       = 4'd8;
   localparam logic [3:0] STP_RD_SETUP = 4'd9;
   localparam logic [3:0] STP_RD_LO    = 4'd10;
   localparam logic [3:0] STP_RD_HI    = 4'd11;
   localparam logic [3:0] STP_AK_A     = 4'd12;
   localparam logic [3:0] STP_AK_B     = 4'd13;
   localparam logic [3:0] STP_AK_C     = 4'd14;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
   localparam logic [1:0] REG_READ_SETUP  = 2'd1;
   localparam logic [1:0] REG_POLL_LIMIT  = 2'd2;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;
   localparam logic [7:0] READ_SETUP_RESET  = 8'd30;
   localparam logic [7:0] POLL_LIMIT_RESET  = 8'd250;

   typedef struct packed {
      logic [7:0] half_period_ticks;
      logic [7:0] read_setup_ticks;
      logic [7:0] ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic       ack_failed;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_level;
      logic       scl_level;
   } rsp_type;

endpackage

// ----- design/i2cm_csr.sv -----
// Configuration registers of the I2C master byte engine, APB-style access.
// Depends on i2cm_pkg.
module i2cm_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output i2cm_pkg::cfg_type  cfg
);

   i2cm_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= i2cm_pkg::HALF_PERIOD_RESET;
         cfg_ff.read_setup_ticks  <= i2cm_pkg::READ_SETUP_RESET;
         cfg_ff.ack_poll_limit    <= i2cm_pkg::POLL_LIMIT_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            i2cm_pkg::REG_HALF_PERIOD: cfg_ff.half_period_ticks <= csr_pwdata[7:0];
            i2cm_pkg::REG_READ_SETUP:  cfg_ff.read_setup_ticks  <= csr_pwdata[7:0];
            i2cm_pkg::REG_POLL_LIMIT:  cfg_ff.ack_poll_limit    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         i2cm_pkg::REG_HALF_PERIOD: csr_prdata = {24'd0, cfg_ff.half_period_ticks};
         i2cm_pkg::REG_READ_SETUP:  csr_prdata = {24'd0, cfg_ff.read_setup_ticks};
         i2cm_pkg::REG_POLL_LIMIT:  csr_prdata = {24'd0, cfg_ff.ack_poll_limit};
         default:                   csr_prdata = 32'd0;
      endcase
   end

endmodule

// ----- design/i2cm_seq.sv -----
// Bus sequencer of the I2C master byte engine: step state, counters and
// the next-state logic for one transaction. Depends on i2cm_pkg.
module i2cm_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [2:0]         func,
   input  logic [7:0]         tx_byte,
   input  logic               send_ack,
   input  logic               sda_sample,
   input  i2cm_pkg::cfg_type  cfg,
   output i2cm_pkg::rsp_type  rsp_next
);

   logic [3:0] step_ff,    step_in;
   logic [3:0] bit_cnt_ff, bit_cnt_in;
   logic [7:0] shift_ff,   shift_in;
   logic [7:0] delay_ff,   delay_in;
   logic [7:0] poll_ff,    poll_in;
   logic       scl_ff,     scl_in;
   logic       sda_ff,     sda_in;
   logic       ack_sel_ff, ack_sel_in;
   logic       timeout_ff, timeout_in;
   logic [7:0] rx_hold_ff, rx_hold_in;

   logic       done;
   logic [7:0] target;
   logic [8:0] delay_inc;
   logic [8:0] poll_inc;

   assign target    = (step_ff == i2cm_pkg::STP_RD_SETUP) ? cfg.read_setup_ticks
                                                          : cfg.half_period_ticks;
   assign delay_inc = {1'b0, delay_ff} + 9'd1;
   assign poll_inc  = {1'b0, poll_ff} + 9'd1;

   always_comb begin
      step_in    = step_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      delay_in   = delay_ff;
      poll_in    = poll_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_sel_in = ack_sel_ff;
      timeout_in = timeout_ff;
      rx_hold_in = rx_hold_ff;
      done       = 1'b0;

      if (step_ff == i2cm_pkg::STP_IDLE) begin
         unique case (func)
            i2cm_pkg::CMD_START: begin
               bit_cnt_in = 4'd0; delay_in = 8'd0;
               sda_in = 1'b1; scl_in = 1'b1;
               step_in = i2cm_pkg::STP_ST_A;
            end
            i2cm_pkg::CMD_STOP: begin
               bit_cnt_in = 4'd0; delay_in = 8'd0;
               sda_in = 1'b0; scl_in = 1'b0;
               step_in = i2cm_pkg::STP_SP_A;
            end
            i2cm_pkg::CMD_WRITE: begin
               bit_cnt_in = 4'd0; delay_in = 8'd0;
               shift_in = tx_byte; scl_in = 1'b0;
               step_in = i2cm_pkg::STP_WR_PRE;
            end
            i2cm_pkg::CMD_WACK: begin
               bit_cnt_in = 4'd0; delay_in = 8'd0;
               sda_in = 1'b1; scl_in = 1'b1;
               poll_in = 8'd0; timeout_in = 1'b0;
               step_in = i2cm_pkg::STP_WA;
            end
            i2cm_pkg::CMD_READ: begin
               bit_cnt_in = 4'd0; delay_in = 8'd0;
               ack_sel_in = send_ack; shift_in = 8'd0; sda_in = 1'b1;
               step_in = i2cm_pkg::STP_RD_SETUP;
            end
            default: ;
         endcase
      end else if (func == i2cm_pkg::CMD_TICK) begin
         if (delay_inc < {1'b0, target}) begin
            delay_in = delay_inc[7:0];
         end else begin
            delay_in = 8'd0;
            unique case (step_ff)
               i2cm_pkg::STP_ST_A: begin
                  sda_in = 1'b0; step_in = i2cm_pkg::STP_ST_B;
               end
               i2cm_pkg::STP_ST_B: begin
                  scl_in = 1'b0; done = 1'b1;
               end
               i2cm_pkg::STP_SP_A: begin
                  scl_in = 1'b1; step_in = i2cm_pkg::STP_SP_B;
               end
               i2cm_pkg::STP_SP_B: begin
                  sda_in = 1'b1; done = 1'b1;
               end
               i2cm_pkg::STP_WR_PRE, i2cm_pkg::STP_WR_LO: begin
                  if (step_ff == i2cm_pkg::STP_WR_LO && bit_cnt_ff[3]) begin
                     done = 1'b1;
                  end else begin
                     // shift out next bit MSB first and raise SCL
                     sda_in     = shift_ff[7];
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_ff + 4'd1;
                     scl_in     = 1'b1;
                     step_in    = i2cm_pkg::STP_WR_HI;
                  end
               end
               i2cm_pkg::STP_WR_HI: begin
                  scl_in = 1'b0; step_in = i2cm_pkg::STP_WR_LO;
               end
               i2cm_pkg::STP_WA: begin
                  if (!sda_sample) begin
                     scl_in = 1'b0; done = 1'b1;
                  end else begin
                     poll_in = poll_inc[8] ? 8'hFF : poll_inc[7:0];
                     if (poll_inc > {1'b0, cfg.ack_poll_limit}) begin
                        // timed out: run a stop
                        timeout_in = 1'b1;
                        scl_in     = 1'b0;
                        sda_in     = 1'b0;
                        step_in    = i2cm_pkg::STP_SP_A;
                     end
                  end
               end
               i2cm_pkg::STP_RD_SETUP: begin
                  scl_in = 1'b0; step_in = i2cm_pkg::STP_RD_LO;
               end
               i2cm_pkg::STP_RD_LO: begin
                  scl_in     = 1'b1;
                  shift_in   = {shift_ff[6:0], sda_sample};
                  bit_cnt_in = bit_cnt_ff + 4'd1;
                  step_in    = i2cm_pkg::STP_RD_HI;
               end
               i2cm_pkg::STP_RD_HI: begin
                  scl_in = 1'b0;
                  if (bit_cnt_ff[3]) begin
                     rx_hold_in = shift_ff;
                     step_in    = i2cm_pkg::STP_AK_A;
                  end else begin
                     step_in = i2cm_pkg::STP_RD_LO;
                  end
               end
               i2cm_pkg::STP_AK_A: begin
                  sda_in = ~ack_sel_ff; step_in = i2cm_pkg::STP_AK_B;
               end
               i2cm_pkg::STP_AK_B: begin
                  scl_in = 1'b1; step_in = i2cm_pkg::STP_AK_C;
               end
               i2cm_pkg::STP_AK_C: begin
                  scl_in = 1'b0; done = 1'b1;
               end
               default: done = 1'b1;
            endcase
            if (done) begin
               step_in = i2cm_pkg::STP_IDLE;
            end
         end
      end
   end

   always_comb begin
      rsp_next.scl_level  = scl_in;
      rsp_next.sda_level  = sda_in;
      rsp_next.busy_res   = (step_in != i2cm_pkg::STP_IDLE);
      rsp_next.done_res   = done;
      rsp_next.rx_byte    = rx_hold_in;
      rsp_next.ack_failed = timeout_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= i2cm_pkg::STP_IDLE;
         bit_cnt_ff <= 4'd0;
         shift_ff   <= 8'd0;
         delay_ff   <= 8'd0;
         poll_ff    <= 8'd0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         ack_sel_ff <= 1'b0;
         timeout_ff <= 1'b0;
         rx_hold_ff <= 8'd0;
      end else if (advance) begin
         step_ff    <= step_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         delay_ff   <= delay_in;
         poll_ff    <= poll_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         ack_sel_ff <= ack_sel_in;
         timeout_ff <= timeout_in;
         rx_hold_ff <= rx_hold_in;
      end
   end

endmodule

// ----- design/i2c_master_byte_engine.sv -----
// I2C master byte engine, top level: config port, sequencer, result register.
// Depends on i2cm_pkg, i2cm_csr and i2cm_seq.
//
// Usage: each req transaction carries a command (tuser) or a time tick
// (tuser = 0) plus the SDA level seen at that tick. While idle the engine
// takes start, stop, write byte, wait ack or read byte; ticks then move the
// command through its SCL/SDA phases, each phase lasting half_period_ticks
// ticks (read_setup_ticks before a read). Commands while busy are dropped.
// Every req transaction produces exactly one rsp transaction with the line
// drives, busy/done flags, last received byte and the ack timeout flag.
// The result appears in the cycle after the req transaction is accepted,
// from a single output register. Throughput: one transaction per cycle
// while rsp_tready stays high; the sequencer step and output registers
// load only on accepted transactions. If the receiver stalls, the output
// register keeps its result and req_tready drops until it is taken, so nothing is lost.
// Reset (synchronous): sequencer idle, SCL and SDA released, counters and
// received byte cleared, output empty, registers at 5, 30 and 250.
// Registers: half_period_ticks at 0x0, read_setup_ticks at 0x4,
// ack_poll_limit at 0x8, 8 bits each; write only while the engine is idle.
module i2c_master_byte_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tx_byte[7:0], send_ack[8], sda_sample[9], zero
   input  logic [2:0]  req_tuser,   // func[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl_level[0], sda_level[1], busy_res[2],
                                    // done_res[3], rx_byte[11:4], ack_failed[12], zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   i2cm_pkg::cfg_type cfg;
   i2cm_pkg::rsp_type rsp_next;
   i2cm_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic              req_fire;

   // accept while the output register is empty or being drained
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   i2cm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   i2cm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_fire),
      .func       (req_tuser),
      .tx_byte    (req_tdata[7:0]),
      .send_ack   (req_tdata[8]),
      .sda_sample (req_tdata[9]),
      .cfg        (cfg),
      .rsp_next   (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_ff.ack_failed, rsp_ff.rx_byte, rsp_ff.done_res,
                        rsp_ff.busy_res, rsp_ff.sda_level, rsp_ff.scl_level};

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while result register is stalled");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |-> !rsp_ff.busy_res)
      else $error("command finished but still reported busy");

   a_half_period_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite &&
       csr_paddr[3:2] == i2cm_pkg::REG_HALF_PERIOD)
      |=> cfg.half_period_ticks == $past(csr_pwdata[7:0]))
      else $error("half period register write lost");

endmodule
